FILE: sv/gpr_pkg.sv
// gpr_pkg: shared types and constants for the grid path reachability block
// command codes, field widths and the controller/datapath command and status structs
// no dependencies
package gpr_pkg;

  // field widths fixed by the interface
  localparam int CMD_W  = 2;
  localparam int CELL_W = 6;
  localparam int REG_W  = 7;
  localparam int IDX_W  = 1;
  // wide enough for any saturated grid size up to 1024
  localparam int SIZE_W = 11;

  localparam logic [REG_W-1:0] GRID_SIZE_RESET = 7'd64;

  // item command codes
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_MARK  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_EVAL  = 2'd2;

  // configuration register indexes
  localparam logic [IDX_W-1:0] CFG_GRID_ROWS = 1'd0;
  localparam logic [IDX_W-1:0] CFG_GRID_COLS = 1'd1;

  // controller to datapath
  typedef struct packed {
    logic row_clr;   // row counter back to zero
    logic row_inc;   // advance row counter
    logic col_clr;   // column counter back to zero
    logic wipe;      // write an all-open row at the row counter
    logic mark;      // block the addressed cell if it lies inside the active grid
    logic rd;        // fetch the row at the row counter
    logic step;      // evaluate one cell and advance the column counter
    logic load_out;  // capture the final reach bit into the output register
  } gpr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic row_last_max;  // row counter at the last physical row
    logic row_last;      // row counter at the last active row
    logic col_last;      // column counter at the last active column
  } gpr_stat_t;

endpackage

FILE: sv/gpr_dpath.sv
// gpr_dpath: occupancy map memory, size registers, counters and the reach recurrence
// evaluates one cell per cycle while the controller issues step, from a registered row read
// depends on gpr_pkg
module gpr_dpath #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [gpr_pkg::IDX_W-1:0]   cfg_index,
  input  logic [gpr_pkg::REG_W-1:0]   cfg_wdata,
  input  logic [gpr_pkg::CELL_W-1:0]  in_cell_row,
  input  logic [gpr_pkg::CELL_W-1:0]  in_cell_col,
  input  gpr_pkg::gpr_cmd_t           cmd,
  output gpr_pkg::gpr_stat_t          stat,
  output logic                        out_path_exists
);
  import gpr_pkg::*;

  localparam int RW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_COLS);

  function automatic logic [SIZE_W-1:0] sat_size(input logic [REG_W-1:0] v,
                                                 input logic [SIZE_W-1:0] lim);
    logic [SIZE_W-1:0] ext;
    ext = SIZE_W'(v);
    if (ext == '0) return SIZE_W'(1);
    if (ext > lim) return lim;
    return ext;
  endfunction

  logic [REG_W-1:0]    grid_rows_r;
  logic [REG_W-1:0]    grid_cols_r;
  logic [SIZE_W-1:0]   rows_act;
  logic [SIZE_W-1:0]   cols_act;
  logic [RW-1:0]       last_row;
  logic [CW-1:0]       last_col;
  logic                mark_ok;

  logic [RW-1:0]       row_r;
  logic [CW-1:0]       col_r;
  logic [MAX_COLS-1:0] map_mem [MAX_ROWS];
  logic [MAX_COLS-1:0] row_data_r;
  logic [MAX_COLS-1:0] reach_r;
  logic                left_r;
  logic                cell_bit;
  logic                out_path_exists_r;

  // size registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_rows_r <= GRID_SIZE_RESET;
      grid_cols_r <= GRID_SIZE_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_GRID_ROWS) grid_rows_r <= cfg_wdata;
      if (cfg_index == CFG_GRID_COLS) grid_cols_r <= cfg_wdata;
    end
  end

  // active grid size, zero treated as one, saturated at the physical size
  assign rows_act = sat_size(grid_rows_r, SIZE_W'(MAX_ROWS));
  assign cols_act = sat_size(grid_cols_r, SIZE_W'(MAX_COLS));
  assign last_row = RW'(rows_act - SIZE_W'(1));
  assign last_col = CW'(cols_act - SIZE_W'(1));
  assign mark_ok  = (SIZE_W'(in_cell_row) < rows_act) && (SIZE_W'(in_cell_col) < cols_act);

  // row and column counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else begin
      if (cmd.row_clr)      row_r <= '0;
      else if (cmd.row_inc) row_r <= row_r + RW'(1);
      if (cmd.col_clr)      col_r <= '0;
      else if (cmd.step)    col_r <= col_r + CW'(1);
    end
  end

  // occupancy map, one row per word, 1 = blocked
  always_ff @(posedge clk) begin
    if (cmd.wipe) begin
      map_mem[row_r] <= '0;
    end else if (cmd.mark && mark_ok) begin
      map_mem[RW'(in_cell_row)][CW'(in_cell_col)] <= 1'b1;
    end
    if (cmd.rd) begin
      row_data_r <= map_mem[row_r];
    end
  end

  // reach recurrence for the current cell; start cell always reached
  always_comb begin
    cell_bit = ((row_r == '0) && (col_r == '0)) ||
               (!row_data_r[col_r] &&
                (((col_r != '0) && left_r) || ((row_r != '0) && reach_r[col_r])));
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      reach_r[col_r] <= cell_bit;
      left_r         <= cell_bit;
    end
    if (cmd.load_out) begin
      out_path_exists_r <= left_r;
    end
  end

  assign stat.row_last_max = (row_r == RW'(MAX_ROWS - 1));
  assign stat.row_last     = (row_r == last_row);
  assign stat.col_last     = (col_r == last_col);
  assign out_path_exists   = out_path_exists_r;

endmodule

FILE: sv/gpr_ctrl.sv
// gpr_ctrl: sequencer for clear sweeps, marks and the row-by-row evaluate walk
// owns the input stall and the output valid
// depends on gpr_pkg
module gpr_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [gpr_pkg::CMD_W-1:0]  in_cmd,
  output logic                       out_valid,
  input  logic                       out_stall,
  output gpr_pkg::gpr_cmd_t          cmd,
  input  gpr_pkg::gpr_stat_t         stat
);
  import gpr_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_CELL,
    ST_DONE
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   accept;
  logic   out_free;

  assign accept   = in_valid && (state_r == ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  // next state and datapath commands
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.wipe = 1'b1;
        if (stat.row_last_max) begin
          cmd.row_clr = 1'b1;
          state_nxt   = ST_IDLE;
        end else begin
          cmd.row_inc = 1'b1;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (in_cmd)
            CMD_CLEAR: state_nxt = ST_CLEAR;
            CMD_MARK:  cmd.mark  = 1'b1;
            CMD_EVAL:  state_nxt = ST_READ;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_READ: begin
        cmd.rd      = 1'b1;
        cmd.col_clr = 1'b1;
        state_nxt   = ST_CELL;
      end
      ST_CELL: begin
        cmd.step = 1'b1;
        if (stat.col_last) begin
          cmd.col_clr = 1'b1;
          if (stat.row_last) begin
            cmd.row_clr = 1'b1;
            state_nxt   = ST_DONE;
          end else begin
            cmd.row_inc = 1'b1;
            state_nxt   = ST_READ;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state and output valid; reset starts a clearing pass over the map
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

FILE: sv/grid_path_reachability.sv
// grid_path_reachability: top level, occupancy grid with right/down reachability check
// instantiates gpr_ctrl and gpr_dpath; depends on gpr_pkg
//
//   channel  ports                                   direction  notes
//   in       in_valid in_stall in_cmd in_cell_row/col  in       clear, mark or evaluate item
//   out      out_valid out_stall out_path_exists        out      one item per evaluate
//   cfg      cfg_we cfg_index cfg_wdata                 in       grid_rows, grid_cols
//
// mark: written in the accepting cycle. clear: the accepting cycle, then one
// map row wiped per cycle over all MAX_ROWS rows.
// evaluate: one cell per cycle plus one row fetch per row from the single
// map memory port.
// reset runs the same clearing pass, with in_stall high throughout.
// the output register holds a result while out_stall is high; clears and marks
// still proceed, and a finished evaluate waits for the register to free up.
module grid_path_reachability #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [gpr_pkg::IDX_W-1:0]   cfg_index,
  input  logic [gpr_pkg::REG_W-1:0]   cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [gpr_pkg::CMD_W-1:0]   in_cmd,
  input  logic [gpr_pkg::CELL_W-1:0]  in_cell_row,
  input  logic [gpr_pkg::CELL_W-1:0]  in_cell_col,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_path_exists
);
  import gpr_pkg::*;

  gpr_cmd_t  cmd;
  gpr_stat_t stat;

  // sequencer
  gpr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_cmd    (in_cmd),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  // map, counters and recurrence
  gpr_dpath #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_cell_row     (in_cell_row),
    .in_cell_col     (in_cell_col),
    .cmd             (cmd),
    .stat            (stat),
    .out_path_exists (out_path_exists)
  );

endmodule
